// File: rtl/bmpt_pkg.sv
package bmpt_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_PAD    = 2'd2,
    PH_IDLE   = 2'd3
  } phase_e;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_X_ORIGIN   = 2'd0;
  localparam logic [1:0] REG_BOTTOM_ROW = 2'd1;
  localparam logic [1:0] REG_THRESHOLD  = 2'd2;

  localparam logic [7:0] X_ORIGIN_RST   = 8'd0;
  localparam logic [7:0] BOTTOM_ROW_RST = 8'd47;
  localparam logic [7:0] THRESHOLD_RST  = 8'd0;

  // header byte positions
  localparam logic [15:0] POS_OFFSET = 16'd10;
  localparam logic [15:0] POS_WIDTH  = 16'd18;
  localparam logic [15:0] POS_HEIGHT = 16'd22;
  localparam logic [7:0]  MIN_OFFSET = 8'd23;

  localparam logic [7:0] THR_MAX = 8'd14;

  localparam int IDX_W = 9;

  typedef struct packed {
    logic [7:0] x_origin;
    logic [7:0] bottom_row;
    logic [7:0] pixel_threshold;
  } cfg_t;

  // one entry of work for the output side: a reject, or up to two bit writes
  typedef struct packed {
    logic             rej;
    logic             v0;
    logic             on0;
    logic [IDX_W-1:0] idx0;
    logic             v1;
    logic             on1;
    logic [IDX_W-1:0] idx1;
    logic             end1;
    logic [2:0]       bit_pos;
  } job_t;

endpackage

// File: rtl/bmpt_if.sv
interface bmpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] bmp_byte;
  logic       file_start;

  modport source (output valid, output bmp_byte, output file_start, input ready);
  modport sink   (input valid, input bmp_byte, input file_start, output ready);
endinterface

interface bmpt_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [8:0] byte_index;
  logic [2:0] bit_pos;
  logic       pixel_on;
  logic       image_end;
  logic       last_of_run;

  modport source (output valid, output kind, output byte_index, output bit_pos,
                  output pixel_on, output image_end, output last_of_run, input ready);
  modport sink   (input valid, input kind, input byte_index, input bit_pos,
                  input pixel_on, input image_end, input last_of_run, output ready);
endinterface

// File: rtl/bmpt_front.sv
module bmpt_front
  import bmpt_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 84,
  parameter int SCREEN_HEIGHT = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmpt_in_if.sink    in_ch,
  input  cfg_t       cfg_i,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  localparam int BW        = (SCREEN_HEIGHT / 8 + 1) > 1 ? $clog2(SCREEN_HEIGHT / 8 + 1) : 1;
  localparam int BUF_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;

  logic [15:0]   file_pos_q, file_pos_d;
  logic [7:0]    offset_q, offset_d;
  logic [7:0]    width_q, width_d;
  phase_e        phase_q, phase_d;
  logic [6:0]    bir_q, bir_d;
  logic [1:0]    pad_q, pad_d;
  logic [7:0]    rows_q, rows_d;
  logic [2:0]    row_bit_q, row_bit_d;
  logic [BW-1:0] band_q, band_d;
  logic [9:0]    wi_q, wi_d;

  logic          acc;
  logic [15:0]   p;
  phase_e        ph;
  logic          do_data;
  logic [7:0]    b;
  logic [3:0]    thr;
  logic [10:0]   idx1;
  logic          row_end;
  logic          last;
  logic          bad;

  assign in_ch.ready = !full_i;
  assign acc = in_ch.valid && !full_i;
  assign b   = in_ch.bmp_byte;
  assign thr = (cfg_i.pixel_threshold > THR_MAX) ? THR_MAX[3:0] : cfg_i.pixel_threshold[3:0];

  function automatic logic [9:0] row_base(input logic [7:0] x, input logic [BW-1:0] band);
    row_base = 10'({2'b00, x} + 10'(SCREEN_WIDTH * int'(band)));
  endfunction

  always_comb begin
    file_pos_d = file_pos_q;
    offset_d   = offset_q;
    width_d    = width_q;
    phase_d    = phase_q;
    bir_d      = bir_q;
    pad_d      = pad_q;
    rows_d     = rows_q;
    row_bit_d  = row_bit_q;
    band_d     = band_q;
    wi_d       = wi_q;
    push_o     = 1'b0;
    job_o      = '0;
    do_data    = 1'b0;
    bad        = 1'b0;
    p          = in_ch.file_start ? 16'd0 : file_pos_q;
    ph         = in_ch.file_start ? PH_HEADER : phase_q;
    idx1       = {1'b0, wi_q} + 11'd1;
    row_end    = (bir_q <= 7'd1);
    last       = row_end && (rows_q <= 8'd1);
    if (acc) begin
      file_pos_d = (p != 16'hFFFF) ? p + 16'd1 : p;
      phase_d    = ph;
      case (ph)
        PH_IDLE: ;
        PH_PAD: begin
          pad_d = pad_q - 2'd1;
          if (pad_d == 2'd0) phase_d = PH_DATA;
        end
        PH_DATA: do_data = 1'b1;
        PH_HEADER: begin
          if (p == POS_OFFSET) begin
            offset_d = b;
          end else if (p == POS_WIDTH) begin
            width_d = b;
          end else if (p == POS_HEIGHT) begin
            bad = (b == 8'd0) || width_q[0] ||
                  (({1'b0, cfg_i.x_origin} + {1'b0, width_q}) > 9'(SCREEN_WIDTH)) ||
                  (({1'b0, cfg_i.bottom_row} + 9'd1) < {1'b0, b}) ||
                  (cfg_i.bottom_row > 8'(SCREEN_HEIGHT)) ||
                  (offset_q < MIN_OFFSET);
            if (bad) begin
              phase_d    = PH_IDLE;
              push_o     = 1'b1;
              job_o.rej  = 1'b1;
            end else if (width_q == 8'd0) begin
              phase_d = PH_IDLE;
            end else begin
              bir_d     = width_q[7:1];
              rows_d    = b;
              row_bit_d = cfg_i.bottom_row[2:0];
              band_d    = BW'(cfg_i.bottom_row >> 3);
              wi_d      = row_base(cfg_i.x_origin, BW'(cfg_i.bottom_row >> 3));
            end
          end else if (p > POS_HEIGHT && p == {8'd0, offset_q}) begin
            phase_d = PH_DATA;
            do_data = 1'b1;
          end
        end
        default: ;
      endcase

      if (do_data) begin
        job_o.v0      = 32'(wi_q) < BUF_BYTES;
        job_o.idx0    = wi_q[IDX_W-1:0];
        job_o.on0     = b[7:4] > thr;
        job_o.v1      = 32'(idx1) < BUF_BYTES;
        job_o.idx1    = idx1[IDX_W-1:0];
        job_o.on1     = b[3:0] > thr;
        job_o.end1    = last;
        job_o.bit_pos = row_bit_q;
        push_o        = job_o.v0 || job_o.v1;
        wi_d  = wi_q + 10'd2;
        bir_d = bir_q - 7'd1;
        if (row_end) begin
          rows_d = rows_q - 8'd1;
          if (rows_d == 8'd0) begin
            phase_d = PH_IDLE;
          end else begin
            if (row_bit_q != 3'd0) begin
              row_bit_d = row_bit_q - 3'd1;
            end else begin
              row_bit_d = 3'd7;
              band_d    = band_q - BW'(1);
            end
            wi_d    = row_base(cfg_i.x_origin, band_d);
            bir_d   = width_q[7:1];
            pad_d   = 2'd0 - bir_d[1:0];
            phase_d = (pad_d != 2'd0) ? PH_PAD : PH_DATA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_pos_q <= '0;
      offset_q   <= '0;
      width_q    <= '0;
      phase_q    <= PH_HEADER;
      bir_q      <= '0;
      pad_q      <= '0;
      rows_q     <= '0;
      row_bit_q  <= '0;
      band_q     <= '0;
      wi_q       <= '0;
    end else begin
      file_pos_q <= file_pos_d;
      offset_q   <= offset_d;
      width_q    <= width_d;
      phase_q    <= phase_d;
      bir_q      <= bir_d;
      pad_q      <= pad_d;
      rows_q     <= rows_d;
      row_bit_q  <= row_bit_d;
      band_q     <= band_d;
      wi_q       <= wi_d;
    end
  end

endmodule

// File: rtl/bmpt_queue.sv
module bmpt_queue
  import bmpt_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] ptr);
    nxt = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

// File: rtl/bmpt_back.sv
module bmpt_back
  import bmpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        job_i,
  input  logic        empty_i,
  output logic        pop_o,
  bmpt_out_if.source  out_ch
);

  logic busy_q, second_q;
  job_t job_q;
  logic fire, done, load;

  assign fire  = out_ch.valid && out_ch.ready;
  assign done  = fire && (job_q.rej || second_q || !job_q.v1);
  assign load  = !empty_i && (!busy_q || done);
  assign pop_o = load;

  assign out_ch.valid       = busy_q;
  assign out_ch.kind        = job_q.rej;
  assign out_ch.byte_index  = job_q.rej ? '0 : (second_q ? job_q.idx1 : job_q.idx0);
  assign out_ch.bit_pos     = job_q.rej ? '0 : job_q.bit_pos;
  assign out_ch.pixel_on    = !job_q.rej && (second_q ? job_q.on1 : job_q.on0);
  assign out_ch.image_end   = !job_q.rej && second_q && job_q.end1;
  assign out_ch.last_of_run = job_q.rej || second_q || !job_q.v1;

  always_ff @(posedge clk_i) begin
    if (load) job_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      second_q <= 1'b0;
    end else if (load) begin
      busy_q   <= 1'b1;
      second_q <= !job_i.v0;  // skip a dropped first write
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      second_q <= 1'b1;
    end
  end

endmodule

// File: rtl/bmp4_threshold_to_bitplane.sv
// The first result of a byte is offered once the byte has passed through the queue and
// the output job register; the second result follows once the first result is taken.
// Throughput: header and padding bytes are accepted one per cycle while the queue is
// not full; a data byte yields up to two bit writes, given one at a time by the single
// result port. A 2-entry queue lets the parser run ahead while results wait to be taken.
// Reset (rst_ni low, asynchronous) clears parser state and queue, and loads
// x_origin 0, bottom_row 47, pixel_threshold 0.
module bmp4_threshold_to_bitplane
  import bmpt_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 84,
  parameter int SCREEN_HEIGHT = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmpt_in_if.sink     in_ch,
  bmpt_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_q;
  logic wr_en;
  logic push, pop, full, empty;
  job_t job_in, job_out;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin        <= X_ORIGIN_RST;
      cfg_q.bottom_row      <= BOTTOM_ROW_RST;
      cfg_q.pixel_threshold <= THRESHOLD_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_X_ORIGIN:   cfg_q.x_origin        <= pwdata[7:0];
        REG_BOTTOM_ROW: cfg_q.bottom_row      <= pwdata[7:0];
        REG_THRESHOLD:  cfg_q.pixel_threshold <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_X_ORIGIN:   prdata = {24'd0, cfg_q.x_origin};
      REG_BOTTOM_ROW: prdata = {24'd0, cfg_q.bottom_row};
      REG_THRESHOLD:  prdata = {24'd0, cfg_q.pixel_threshold};
      default:        prdata = '0;
    endcase
  end

  bmpt_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .cfg_i (cfg_q),
    .full_i(full),
    .push_o(push),
    .job_o (job_in)
  );

  bmpt_queue #(
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .pop_i  (pop),
    .data_o (job_out),
    .full_o (full),
    .empty_o(empty)
  );

  bmpt_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_out),
    .empty_i(empty),
    .pop_o  (pop),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/bmpt_checker.sv
module bmpt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       kind_i,
  input logic [8:0] byte_index_i,
  input logic       pixel_on_i,
  input logic       image_end_i,
  input logic       last_of_run_i
);

  // a stalled result keeps its place
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_index_i) && $stable(kind_i))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

  a_reject_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i |-> last_of_run_i && !image_end_i && !pixel_on_i &&
                              byte_index_i == 9'd0)
    else $error("malformed reject item");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && image_end_i |-> last_of_run_i && !kind_i)
    else $error("image end not on last write of its byte");

endmodule

bind bmp4_threshold_to_bitplane bmpt_checker u_bmpt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .kind_i       (out_ch.kind),
  .byte_index_i (out_ch.byte_index),
  .pixel_on_i   (out_ch.pixel_on),
  .image_end_i  (out_ch.image_end),
  .last_of_run_i(out_ch.last_of_run)
);
